/* src/base64_stream_encoder_core_assert.svh */
// Assertion macros used by the encoder's checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define B64_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64 encoder check failed");

// Next-cycle implication, held off during reset.
`define B64_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64 encoder check failed");

`endif

/* src/b64_enc_pkg.sv */
// Package for the base64 stream encoder: group type, pad code and alphabet lookup.
// No dependencies.
package b64_enc_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;

    // One byte group handed from the front end to the character back end.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] count;   // real bytes in the group, 1 to 3
        logic       fin;     // group closes the message
    } b64_group_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] ch;
        ch = 7'd0;
        case (v) inside
            [6'd0:6'd25]:  ch = 7'(v) + 7'd65;
            [6'd26:6'd51]: ch = 7'(v) + 7'd71;
            [6'd52:6'd61]: ch = 7'(v) - 7'd4;
            6'd62:         ch = 7'd43;
            6'd63:         ch = 7'd47;
            default:       ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage

/* src/b64_enc_if.sv */
// Stream interfaces of the base64 encoder: raw byte input and character output.
// No dependencies.
interface b64_enc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64_enc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       final_char;

    modport source (output valid, output out_char, output final_char, input ready);
    modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

/* src/base64_stream_encoder_core.sv */
// Base64 (standard alphabet) stream encoder, top level.
// Each group is registered in a queue slot, then cur_reg, then the output register.
// Throughput: one byte per cycle in while the queue has room, and one character
// per cycle out while the receiver is ready.
// Reset: asynchronous, active low; clears the group position, the queue and all valids.
// Depends on b64_enc_pkg, b64_enc_if, b64_enc_front, b64_enc_queue and b64_enc_back.
module base64_stream_encoder_core
    import b64_enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    b64_enc_in_if.sink    byte_in,
    b64_enc_out_if.source char_out
);

    // Groups travel from the byte collector to the character emitter through
    // a short queue, so a stalled output does not stop bytes from coming in
    // until the queue has filled.
    logic       push;
    b64_group_t push_group;
    logic       pop;
    b64_group_t head_group;
    logic       queue_full;
    logic       queue_empty;

    // Collect bytes; hand over a group when it is complete or the message ends.
    b64_enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .queue_full (queue_full),
        .push       (push),
        .push_group (push_group)
    );

    // Hold groups waiting for the emitter.
    b64_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .pop_group  (head_group),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    // Emit four characters per group, padding with '=' past the real bytes.
    b64_enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_group  (head_group),
        .pop         (pop),
        .char_out    (char_out)
    );

endmodule

/* src/b64_enc_front.sv */
// Front end: accept bytes, collect them into three-byte groups, queue groups.
// Depends on b64_enc_pkg and b64_enc_in_if.
module b64_enc_front
    import b64_enc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b64_enc_in_if.sink   byte_in,
    input  logic         queue_full,
    output logic         push,
    output b64_group_t   push_group
);

    logic [1:0] pos_reg, pos_next;
    logic [7:0] b0_reg, b0_next;
    logic [7:0] b1_reg, b1_next;
    logic       accept;
    logic [1:0] pos;

    assign byte_in.ready = !queue_full;
    assign accept        = byte_in.valid && byte_in.ready;
    // A position of three cannot arise; treat it as a group start.
    assign pos           = (pos_reg == 2'd3) ? 2'd0 : pos_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        push       = 1'b0;
        push_group = '{byte0: b0_reg, byte1: b1_reg, byte2: byte_in.data_byte,
                       count: 2'd3, fin: byte_in.end_of_message};
        if (accept)
        begin
            case (pos)
                2'd2:
                begin
                    push     = 1'b1;
                    pos_next = 2'd0;
                    b0_next  = 8'd0;
                    b1_next  = 8'd0;
                end
                2'd1:
                begin
                    if (byte_in.end_of_message)
                    begin
                        push       = 1'b1;
                        push_group = '{byte0: b0_reg, byte1: byte_in.data_byte,
                                       byte2: 8'd0, count: 2'd2, fin: 1'b1};
                        pos_next   = 2'd0;
                        b0_next    = 8'd0;
                        b1_next    = 8'd0;
                    end
                    else
                    begin
                        b1_next  = byte_in.data_byte;
                        pos_next = 2'd2;
                    end
                end
                default:
                begin
                    if (byte_in.end_of_message)
                    begin
                        push       = 1'b1;
                        push_group = '{byte0: byte_in.data_byte, byte1: 8'd0,
                                       byte2: 8'd0, count: 2'd1, fin: 1'b1};
                        pos_next   = 2'd0;
                        b0_next    = 8'd0;
                    end
                    else
                    begin
                        b0_next  = byte_in.data_byte;
                        pos_next = 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            b0_reg  <= 8'd0;
            b1_reg  <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            b0_reg  <= b0_next;
            b1_reg  <= b1_next;
        end
    end

endmodule

/* src/b64_enc_queue.sv */
// Group queue between front and back end.
// Depends on b64_enc_pkg.
module b64_enc_queue
    import b64_enc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  b64_group_t push_group,
    input  logic       pop,
    output b64_group_t pop_group,
    output logic       full,
    output logic       empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    b64_group_t      slot_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_group = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_group;
    end

endmodule

/* src/b64_enc_back.sv */
// Back end: take queued groups and emit four characters each through an output register.
// Depends on b64_enc_pkg and b64_enc_out_if.
module b64_enc_back
    import b64_enc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          queue_empty,
    input  b64_group_t    head_group,
    output logic          pop,
    b64_enc_out_if.source char_out
);

    b64_group_t cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [6:0] char_reg, char_next;
    logic       fin_reg, fin_next;
    logic       ovalid_reg, ovalid_next;
    logic       can_load, load;
    logic [5:0] sextet;
    logic [6:0] ch;

    assign can_load = !ovalid_reg || char_out.ready;
    assign load     = cur_valid_reg && can_load;
    assign pop      = !queue_empty && (!cur_valid_reg || (load && idx_reg == 2'd3));

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = cur_reg.byte0[7:2];
            2'd1:    sextet = {cur_reg.byte0[1:0], cur_reg.byte1[7:4]};
            2'd2:    sextet = {cur_reg.byte1[3:0], cur_reg.byte2[7:6]};
            default: sextet = cur_reg.byte2[5:0];
        endcase
        ch = (idx_reg > cur_reg.count) ? PAD_CHAR : sextet_char(sextet);
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        fin_next       = fin_reg;
        ovalid_next    = ovalid_reg;
        if (char_out.ready)
            ovalid_next = 1'b0;
        if (load)
        begin
            char_next   = ch;
            fin_next    = cur_reg.fin && (idx_reg == 2'd3);
            ovalid_next = 1'b1;
            idx_next    = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
                cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_next       = head_group;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        char_reg <= char_next;
        fin_reg  <= fin_next;
    end

    assign char_out.valid      = ovalid_reg;
    assign char_out.out_char   = char_reg;
    assign char_out.final_char = fin_reg;

endmodule

/* src/b64_enc_checker.sv */
// Port-level checks for the base64 encoder, bound to the top level.
// Depends on b64_enc_pkg and base64_stream_encoder_core_assert.svh.
`include "base64_stream_encoder_core_assert.svh"

module b64_enc_checker
    import b64_enc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_char,
    input logic       final_char
);

    // A stalled character holds.
    `B64_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(final_char))

    // Only alphabet characters or the pad leave the block.
    `B64_ASSERT_IMPL(a_char_legal, out_valid, (out_char >= 7'd65 && out_char <= 7'd90) || (out_char >= 7'd97 && out_char <= 7'd122) || (out_char >= 7'd48 && out_char <= 7'd57) || out_char == 7'd43 || out_char == 7'd47 || out_char == PAD_CHAR)

    // A pad that does not end the message is followed at once by another pad.
    `B64_ASSERT_NEXT(a_pad_run, out_valid && out_ready && out_char == PAD_CHAR && !final_char, out_valid && out_char == PAD_CHAR)

endmodule

bind base64_stream_encoder_core b64_enc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (char_out.valid),
    .out_ready  (char_out.ready),
    .out_char   (char_out.out_char),
    .final_char (char_out.final_char)
);
